// ===== sv/vng_pkg.sv =====
// Shared types, constants and offset tables for the voxel neighbour generator.
package vng_pkg;

    localparam int COORD_BITS   = 10;
    localparam int SUBJECT_BITS = 8;

    // Candidate slots: 27 cube positions followed by 6 far positions.
    // The face pattern reuses the first six slots with its own table.
    localparam int CUBE_SLOTS = 27;
    localparam int FAR_SLOTS  = 6;
    localparam int FACE_SLOTS = 6;
    localparam int NUM_SLOTS  = CUBE_SLOTS + FAR_SLOTS;
    localparam int SLOT_BITS  = $clog2(NUM_SLOTS);

    // An offset index of 0..4 stands for -2..+2; index 2 is no offset.
    localparam logic [2:0] OFFS_ZERO = 3'd2;

    typedef enum logic [1:0] {
        CFG_MAX_X = 2'd0,
        CFG_MAX_Y = 2'd1,
        CFG_MAX_Z = 2'd2,
        CFG_MODE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_6  = 2'd0,
        MODE_18 = 2'd1,
        MODE_26 = 2'd2,
        MODE_32 = 2'd3
    } t_mode;

    typedef struct packed {
        logic [2:0] dz;
        logic [2:0] dy;
        logic [2:0] dx;
    } t_offs;

    // One classified centre voxel with its mask of in-bounds candidates.
    typedef struct packed {
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [COORD_BITS-1:0]   cz;
        logic [SUBJECT_BITS-1:0] subj;
        logic [NUM_SLOTS-1:0]    mask;
    } t_job;

    // Face order: z-1, y-1, x-1, z+1, y+1, x+1.
    localparam logic [2:0] FACE_DZ [FACE_SLOTS] = '{3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2};
    localparam logic [2:0] FACE_DY [FACE_SLOTS] = '{3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd2};
    localparam logic [2:0] FACE_DX [FACE_SLOTS] = '{3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3};

    // Far order: z-2, y-2, x-2, x+2, y+2, z+2.
    localparam logic [2:0] FAR_DZ [FAR_SLOTS] = '{3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4};
    localparam logic [2:0] FAR_DY [FAR_SLOTS] = '{3'd2, 3'd0, 3'd2, 3'd2, 3'd4, 3'd2};
    localparam logic [2:0] FAR_DX [FAR_SLOTS] = '{3'd2, 3'd2, 3'd0, 3'd4, 3'd2, 3'd2};

    // Offset of a candidate slot. Cube slots run dz outer, dy, dx inner.
    function automatic t_offs slot_offs(input logic is_face,
                                        input logic [SLOT_BITS-1:0] slot);
        t_offs      offs;
        logic [2:0] far_idx;
        offs    = '{dz: OFFS_ZERO, dy: OFFS_ZERO, dx: OFFS_ZERO};
        far_idx = 3'(slot - SLOT_BITS'(CUBE_SLOTS));
        if (is_face) begin
            if (slot < SLOT_BITS'(FACE_SLOTS)) begin
                offs = '{dz: FACE_DZ[3'(slot)], dy: FACE_DY[3'(slot)],
                         dx: FACE_DX[3'(slot)]};
            end
        end else if (slot < SLOT_BITS'(CUBE_SLOTS)) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (slot == SLOT_BITS'(a * 9 + b * 3 + c)) begin
                            offs = '{dz: 3'(a + 1), dy: 3'(b + 1), dx: 3'(c + 1)};
                        end
                    end
                end
            end
        end else if (slot < SLOT_BITS'(NUM_SLOTS)) begin
            offs = '{dz: FAR_DZ[far_idx], dy: FAR_DY[far_idx], dx: FAR_DX[far_idx]};
        end
        return offs;
    endfunction

    // Whether a slot belongs to the pattern of the given mode.
    function automatic logic slot_en(input t_mode mode, input logic [SLOT_BITS-1:0] slot);
        t_offs o;
        logic  centre;
        logic  corner;
        logic  en;
        o      = slot_offs(1'b0, slot);
        centre = (o.dz == OFFS_ZERO) && (o.dy == OFFS_ZERO) && (o.dx == OFFS_ZERO);
        corner = (o.dz != OFFS_ZERO) && (o.dy != OFFS_ZERO) && (o.dx != OFFS_ZERO);
        unique case (mode)
            MODE_6:  en = slot < SLOT_BITS'(FACE_SLOTS);
            MODE_18: en = (slot < SLOT_BITS'(CUBE_SLOTS)) && !centre && !corner;
            MODE_26: en = (slot < SLOT_BITS'(CUBE_SLOTS)) && !centre;
            MODE_32: en = (slot < SLOT_BITS'(NUM_SLOTS)) && !centre;
            default: en = 1'b0;
        endcase
        return en;
    endfunction

endpackage

// ===== sv/voxel_neighbour_generator.sv =====
// Top level of the voxel neighbour generator: registers, front end, queue, back end.
// Throughput: one result per cycle while results are taken and jobs wait; the back
// end emits one slot of its mask per cycle. A voxel gives one result per in-bounds
// neighbour (up to 32), or a single empty result if it has none.
// A two-entry queue lets new voxels be taken while the back end is still emitting.
// Reset is synchronous and active low: it empties the queue and output and sets the
// bounds to 255 and the pattern to 26 neighbours.
module voxel_neighbour_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_x,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_y,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_z,
    input  logic [vng_pkg::SUBJECT_BITS-1:0] i_subject_id,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_x,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_y,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_z,
    output logic [vng_pkg::SUBJECT_BITS-1:0] o_nbr_subject,
    output logic                             o_found,
    output logic                             o_last
);
    import vng_pkg::*;

    logic [COORD_BITS-1:0] r_max_x;
    logic [COORD_BITS-1:0] r_max_y;
    logic [COORD_BITS-1:0] r_max_z;
    t_mode                 r_mode;

    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic in_xfer;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= COORD_BITS'(255);
            r_max_y <= COORD_BITS'(255);
            r_max_z <= COORD_BITS'(255);
            r_mode  <= MODE_26;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
                CFG_MAX_Z: r_max_z <= i_cfg_data;
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign o_in_ready = !queue_full;
    assign in_xfer    = i_in_valid && o_in_ready;

    vng_front u_front (
        .i_centre_x  (i_centre_x),
        .i_centre_y  (i_centre_y),
        .i_centre_z  (i_centre_z),
        .i_subject_id(i_subject_id),
        .i_max_x     (r_max_x),
        .i_max_y     (r_max_y),
        .i_max_z     (r_max_z),
        .i_mode      (r_mode),
        .o_job       (front_job)
    );

    vng_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_xfer),
        .i_data (front_job),
        .o_full (queue_full),
        .i_pop  (queue_pop),
        .o_valid(queue_valid),
        .o_data (queue_job)
    );

    vng_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (queue_valid),
        .i_job        (queue_job),
        .i_mode       (r_mode),
        .o_job_pop    (queue_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_nbr_x      (o_nbr_x),
        .o_nbr_y      (o_nbr_y),
        .o_nbr_z      (o_nbr_z),
        .o_nbr_subject(o_nbr_subject),
        .o_found      (o_found),
        .o_last       (o_last)
    );

endmodule

// ===== sv/vng_front.sv =====
// Front end: classifies a centre voxel into a mask of in-bounds candidates.
module vng_front (
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_x,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_y,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_centre_z,
    input  logic [vng_pkg::SUBJECT_BITS-1:0] i_subject_id,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_max_x,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_max_y,
    input  logic [vng_pkg::COORD_BITS-1:0]   i_max_z,
    input  vng_pkg::t_mode                   i_mode,
    output vng_pkg::t_job                    o_job
);
    import vng_pkg::*;

    logic [4:0] ok_x;
    logic [4:0] ok_y;
    logic [4:0] ok_z;

    // Per axis, which of the offsets -2..+2 stay within 0..max.
    function automatic logic [4:0] axis_ok(input logic [COORD_BITS-1:0] c,
                                           input logic [COORD_BITS-1:0] m);
        logic [COORD_BITS:0] ce;
        logic [COORD_BITS:0] me;
        logic [4:0]          ok;
        ce    = {1'b0, c};
        me    = {1'b0, m};
        ok[0] = (ce >= (COORD_BITS+1)'(2)) && ((ce - (COORD_BITS+1)'(2)) <= me);
        ok[1] = (ce >= (COORD_BITS+1)'(1)) && ((ce - (COORD_BITS+1)'(1)) <= me);
        ok[2] = ce <= me;
        ok[3] = (ce + (COORD_BITS+1)'(1)) <= me;
        ok[4] = (ce + (COORD_BITS+1)'(2)) <= me;
        return ok;
    endfunction

    assign ok_x = axis_ok(i_centre_x, i_max_x);
    assign ok_y = axis_ok(i_centre_y, i_max_y);
    assign ok_z = axis_ok(i_centre_z, i_max_z);

    // Each candidate slot is enabled by the mode and tested on all three axes.
    always_comb begin
        t_offs o;
        o_job.cx   = i_centre_x;
        o_job.cy   = i_centre_y;
        o_job.cz   = i_centre_z;
        o_job.subj = i_subject_id;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            o = slot_offs(i_mode == MODE_6, SLOT_BITS'(k));
            o_job.mask[k] = slot_en(i_mode, SLOT_BITS'(k)) &&
                            ok_x[o.dx] && ok_y[o.dy] && ok_z[o.dz];
        end
    end

endmodule

// ===== sv/vng_fifo.sv =====
// Two-entry job queue between the front end and the back end.
module vng_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vng_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vng_pkg::t_job o_data
);
    import vng_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage is written only on a push.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== sv/vng_back.sv =====
// Back end: walks a job's candidate mask and emits one neighbour per cycle while results are taken.
module vng_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  vng_pkg::t_job                    i_job,
    input  vng_pkg::t_mode                   i_mode,
    output logic                             o_job_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_x,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_y,
    output logic [vng_pkg::COORD_BITS-1:0]   o_nbr_z,
    output logic [vng_pkg::SUBJECT_BITS-1:0] o_nbr_subject,
    output logic                             o_found,
    output logic                             o_last
);
    import vng_pkg::*;

    logic                    r_cur_valid;
    t_job                    r_cur;
    logic                    r_out_valid;
    logic [COORD_BITS-1:0]   r_nbr_x;
    logic [COORD_BITS-1:0]   r_nbr_y;
    logic [COORD_BITS-1:0]   r_nbr_z;
    logic [SUBJECT_BITS-1:0] r_nbr_subject;
    logic                    r_found;
    logic                    r_last;

    logic [SLOT_BITS-1:0]    sel;
    logic [NUM_SLOTS-1:0]    rest;
    t_offs                   offs;
    logic                    any;
    logic                    last_now;
    logic                    load_out;
    logic [COORD_BITS-1:0]   n_nbr_x;
    logic [COORD_BITS-1:0]   n_nbr_y;
    logic [COORD_BITS-1:0]   n_nbr_z;

    // Lowest pending slot comes first, which keeps the pattern order.
    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_cur.mask[i]) begin
                sel = SLOT_BITS'(i);
            end
        end
    end

    assign rest     = r_cur.mask & (r_cur.mask - NUM_SLOTS'(1));
    assign any      = r_cur.mask != '0;
    assign last_now = !any || (rest == '0);
    assign offs     = slot_offs(i_mode == MODE_6, sel);
    assign n_nbr_x  = any ? r_cur.cx + COORD_BITS'(offs.dx) - COORD_BITS'(OFFS_ZERO) : '0;
    assign n_nbr_y  = any ? r_cur.cy + COORD_BITS'(offs.dy) - COORD_BITS'(OFFS_ZERO) : '0;
    assign n_nbr_z  = any ? r_cur.cz + COORD_BITS'(offs.dz) - COORD_BITS'(OFFS_ZERO) : '0;

    assign load_out  = r_cur_valid && (!r_out_valid || i_out_ready);
    assign o_job_pop = i_job_valid && (!r_cur_valid || (load_out && last_now));

    // Current job: take a new one from the queue when idle or as its last result is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
        end else if (o_job_pop) begin
            r_cur_valid <= 1'b1;
        end else if (load_out && last_now) begin
            r_cur_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_cur <= i_job;
        end else if (load_out) begin
            r_cur.mask <= rest;
        end
    end

    // Output register: one result transfer per cycle while the consumer is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_nbr_x       <= n_nbr_x;
            r_nbr_y       <= n_nbr_y;
            r_nbr_z       <= n_nbr_z;
            r_nbr_subject <= r_cur.subj;
            r_found       <= any;
            r_last        <= last_now;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_nbr_x       = r_nbr_x;
    assign o_nbr_y       = r_nbr_y;
    assign o_nbr_z       = r_nbr_z;
    assign o_nbr_subject = r_nbr_subject;
    assign o_found       = r_found;
    assign o_last        = r_last;

endmodule

// ===== sv/vng_checker.sv =====
// Port-level checks for the voxel neighbour generator, bound to the top level.
module vng_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [vng_pkg::COORD_BITS-1:0]   o_nbr_x,
    input logic [vng_pkg::COORD_BITS-1:0]   o_nbr_y,
    input logic [vng_pkg::COORD_BITS-1:0]   o_nbr_z,
    input logic [vng_pkg::SUBJECT_BITS-1:0] o_nbr_subject,
    input logic                             o_found,
    input logic                             o_last
);

    // A result that waits for the consumer holds all of its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_nbr_x) &&
        $stable(o_nbr_y) && $stable(o_nbr_z) && $stable(o_nbr_subject) &&
        $stable(o_found) && $stable(o_last))
        else $error("result changed while stalled");

    // An empty neighbourhood is a single result that closes the voxel.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last)
        else $error("empty result without last");

    // An empty neighbourhood reports zero coordinates.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_nbr_x == '0) && (o_nbr_y == '0) && (o_nbr_z == '0))
        else $error("empty result with coordinates");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind voxel_neighbour_generator vng_checker u_vng_checker (.*);

// ===== tb/sv/voxel_neighbour_generator_tb.sv =====
// Self-checking testbench for the voxel neighbour generator with random idling on both sides.
module voxel_neighbour_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vng_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 25;
    localparam int PHASES       = 8;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [SUBJECT_BITS-1:0] t_subject;

    // One neighbour result as it should leave the block.
    typedef struct {
        t_coord   x;
        t_coord   y;
        t_coord   z;
        t_subject subject;
        logic     found;
        logic     last;
    } t_nbr_result;

    logic     i_clk        = 1'b0;
    logic     i_rst_n      = 1'b0;
    logic     i_cfg_we     = 1'b0;
    logic     [1:0] i_cfg_idx = '0;
    t_coord   i_cfg_data   = '0;
    logic     i_in_valid   = 1'b0;
    logic     o_in_ready;
    t_coord   i_centre_x   = '0;
    t_coord   i_centre_y   = '0;
    t_coord   i_centre_z   = '0;
    t_subject i_subject_id = '0;
    logic     o_out_valid;
    logic     i_out_ready  = 1'b0;
    t_coord   o_nbr_x;
    t_coord   o_nbr_y;
    t_coord   o_nbr_z;
    t_subject o_nbr_subject;
    logic     o_found;
    logic     o_last;

    // Shadow copy of the configuration registers.
    t_coord cfg_max_x = t_coord'(255);
    t_coord cfg_max_y = t_coord'(255);
    t_coord cfg_max_z = t_coord'(255);
    t_mode  cfg_mode  = MODE_26;

    t_nbr_result expected_nbrs[$];
    t_nbr_result oldest_nbr;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;

    voxel_neighbour_generator uut (.*);

    // Free-running clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Neighbours of one centre voxel under the current bounds and pattern.
    function automatic void predict_neighbours(input t_coord cx, input t_coord cy,
                                               input t_coord cz, input t_subject subj);
        int          face_z[6] = '{-1, 0, 0, 1, 0, 0};
        int          face_y[6] = '{0, -1, 0, 0, 1, 0};
        int          face_x[6] = '{0, 0, -1, 0, 0, 1};
        int          far_z[6]  = '{-2, 0, 0, 0, 0, 2};
        int          far_y[6]  = '{0, -2, 0, 0, 2, 0};
        int          far_x[6]  = '{0, 0, -2, 2, 0, 0};
        int          step_z[$];
        int          step_y[$];
        int          step_x[$];
        t_nbr_result hits[$];
        t_nbr_result r;
        int          nx;
        int          ny;
        int          nz;
        bit          is_centre;
        bit          is_corner;
        if (cfg_mode == MODE_6) begin
            for (int i = 0; i < 6; i++) begin
                step_z = {step_z, face_z[i]};
                step_y = {step_y, face_y[i]};
                step_x = {step_x, face_x[i]};
            end
        end else begin
            // Cube walk: dz outermost, dx innermost.
            for (int dz = -1; dz <= 1; dz++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        is_centre = (dz == 0) && (dy == 0) && (dx == 0);
                        is_corner = (dz != 0) && (dy != 0) && (dx != 0);
                        if (!is_centre && !(cfg_mode == MODE_18 && is_corner)) begin
                            step_z = {step_z, dz};
                            step_y = {step_y, dy};
                            step_x = {step_x, dx};
                        end
                    end
                end
            end
            if (cfg_mode == MODE_32) begin
                for (int i = 0; i < 6; i++) begin
                    step_z = {step_z, far_z[i]};
                    step_y = {step_y, far_y[i]};
                    step_x = {step_x, far_x[i]};
                end
            end
        end
        // Keep only the candidates that fall within the inclusive bounds.
        for (int k = 0; k < step_z.size(); k++) begin
            nx = int'(cx) + step_x[k];
            ny = int'(cy) + step_y[k];
            nz = int'(cz) + step_z[k];
            if (nx >= 0 && nx <= int'(cfg_max_x) && ny >= 0 && ny <= int'(cfg_max_y) &&
                nz >= 0 && nz <= int'(cfg_max_z)) begin
                r = '{x: t_coord'(nx), y: t_coord'(ny), z: t_coord'(nz),
                      subject: subj, found: 1'b1, last: 1'b0};
                hits = {hits, r};
            end
        end
        if (hits.size() == 0) begin
            r = '{x: '0, y: '0, z: '0, subject: subj, found: 1'b0, last: 1'b1};
            hits = {hits, r};
        end else begin
            hits[hits.size() - 1].last = 1'b1;
        end
        foreach (hits[i]) expected_nbrs = {expected_nbrs, hits[i]};
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every output transfer with the oldest pending neighbour.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_nbrs.size() == 0) begin
                $error("nbr_x: expected none, actual %0d (result with nothing pending)",
                       o_nbr_x);
                mismatches++;
            end else begin
                oldest_nbr = expected_nbrs.pop_front();
                check_field("nbr_x", 16'(oldest_nbr.x), 16'(o_nbr_x));
                check_field("nbr_y", 16'(oldest_nbr.y), 16'(o_nbr_y));
                check_field("nbr_z", 16'(oldest_nbr.z), 16'(o_nbr_z));
                check_field("nbr_subject", 16'(oldest_nbr.subject), 16'(o_nbr_subject));
                check_field("found", 16'(oldest_nbr.found), 16'(o_found));
                check_field("last", 16'(oldest_nbr.last), 16'(o_last));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** voxel_neighbour_generator: FAILED **");
            $finish;
        end
    end

    // Result side: an optional random stall before each transfer, then ready held until it happens.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one centre voxel after an optional random gap and wait for its transfer.
    task automatic send_voxel(input t_coord x, input t_coord y, input t_coord z,
                              input t_subject subj);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_centre_x   <= x;
        i_centre_y   <= y;
        i_centre_z   <= z;
        i_subject_id <= subj;
        do @(posedge i_clk); while (!o_in_ready);
        predict_neighbours(x, y, z, subj);
    endtask

    // Stop offering voxels and let every pending neighbour come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_nbrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_coord data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MAX_X: cfg_max_x = data;
            CFG_MAX_Y: cfg_max_y = data;
            CFG_MAX_Z: cfg_max_z = data;
            CFG_MODE:  cfg_mode  = t_mode'(data[1:0]);
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block has gone idle.
    task automatic apply_config(input t_coord mx, input t_coord my, input t_coord mz,
                                input t_mode mode);
        drain_results();
        write_reg(CFG_MAX_X, mx);
        write_reg(CFG_MAX_Y, my);
        write_reg(CFG_MAX_Z, mz);
        // Upper data bits are don't-care for the pattern register.
        write_reg(CFG_MODE, {8'($urandom_range(0, 255)), 2'(mode)});
    endtask

    // Bounds of 255 and the 26-neighbour pattern straight out of reset.
    task automatic test_reset_defaults();
        send_voxel(10'd0, 10'd0, 10'd0, 8'd0);
        send_voxel(10'd255, 10'd255, 10'd255, 8'd255);
        send_voxel(10'd100, 10'd100, 10'd100, 8'h5a);
        send_voxel(10'd256, 10'd100, 10'd100, 8'ha5);
        send_voxel(10'd1023, 10'd1023, 10'd1023, 8'h01);
    endtask

    // Each pattern at the extremes of the coordinate range.
    task automatic test_all_modes();
        t_mode mode;
        for (int m = 0; m < 4; m++) begin
            mode = t_mode'(m);
            src_idle_on  = (m % 2) == 0;
            sink_idle_on = m >= 2;
            apply_config(10'd1023, 10'd1023, 10'd1023, mode);
            send_voxel(10'd0, 10'd0, 10'd0, 8'(m));
            send_voxel(10'd1023, 10'd1023, 10'd1023, 8'(255 - m));
            send_voxel(10'd1, 10'd511, 10'd1022, 8'h80);
        end
    endtask

    // Zero bounds leave at most one far neighbour, usually none.
    task automatic test_empty_neighbourhood();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        apply_config(10'd0, 10'd0, 10'd0, MODE_32);
        send_voxel(10'd0, 10'd0, 10'd0, 8'h3c);
        send_voxel(10'd2, 10'd0, 10'd0, 8'hc3);
        send_voxel(10'd1023, 10'd1023, 10'd1023, 8'haa);
        apply_config(10'd0, 10'd0, 10'd0, MODE_6);
        send_voxel(10'd1, 10'd1, 10'd0, 8'h55);
    endtask

    function automatic t_coord pick_bound();
        case ($urandom_range(0, 4))
            0, 1:    return t_coord'($urandom_range(0, 7));
            2:       return t_coord'($urandom_range(0, 1023));
            3:       return t_coord'(1023);
            default: return '0;
        endcase
    endfunction

    // Centres mostly sit near an edge of the box so that clipping matters.
    function automatic t_coord pick_centre(input t_coord bound);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 1023);
            1:       v = $urandom_range(0, 3);
            default: v = int'(bound) + $urandom_range(0, 6) - 3;
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return t_coord'(v);
    endfunction

    // Random voxels under new random bounds and the next pattern in every phase.
    task automatic test_random_voxels();
        for (int p = 0; p < PHASES; p++) begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            apply_config(pick_bound(), pick_bound(), pick_bound(), t_mode'(p % 4));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 8 == 7) begin
                    src_idle_on  = $urandom_range(0, 2) != 0;
                    sink_idle_on = $urandom_range(0, 2) != 0;
                end
                send_voxel(pick_centre(cfg_max_x), pick_centre(cfg_max_y),
                           pick_centre(cfg_max_z), t_subject'($urandom_range(0, 255)));
            end
        end
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_all_modes();
        test_empty_neighbourhood();
        test_random_voxels();
        drain_results();
        if (mismatches == 0) begin
            $display("** voxel_neighbour_generator: PASSED **");
        end else begin
            $display("** voxel_neighbour_generator: FAILED **");
        end
        $finish;
    end

endmodule
